### src/bmft_pkg.sv
// ----------------------------------------------------------------------------
// bmft_pkg
// Shared constants, codes and types of the block-mapped flash translation core.
// ----------------------------------------------------------------------------
package bmft_pkg;

	// Geometry defaults
	localparam int PAGES_IN_BLOCK  = 32;
	localparam int PHYSICAL_BLOCKS = 64;
	localparam int LOGICAL_BLOCKS  = 63;

	// Field widths
	localparam int LSN_W   = 11;
	localparam int ADDR_W  = 11;
	localparam int OFF_W   = $clog2(PAGES_IN_BLOCK);
	localparam int LBN_W   = LSN_W - OFF_W;
	localparam int LBN_SPAN = 2 ** LBN_W;

	// Flash command codes
	typedef enum logic [2:0] {
		OP_READ    = 3'd0,
		OP_PROGRAM = 3'd1,
		OP_COPY    = 3'd2,
		OP_ERASE   = 3'd3,
		OP_ERROR   = 3'd4
	} op_t;

	// Error codes
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_NO_EMPTY = 2'd1,
		ERR_UNMAPPED = 2'd2
	} err_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP,
		ST_PWR,
		ST_SPR,
		ST_SCAN,
		ST_COPY,
		ST_PROG,
		ST_ERASE
	} state_t;

endpackage

### src/bmft_if.sv
// ----------------------------------------------------------------------------
// bmft_if
// Request and result channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface bmft_req_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [bmft_pkg::LSN_W-1:0]  lsn;

	modport source (output valid, command, lsn, input ready);
	modport sink   (input valid, command, lsn, output ready);
endinterface

interface bmft_res_if;
	logic                        valid;
	logic                        ready;
	bmft_pkg::op_t               op;
	logic [bmft_pkg::ADDR_W-1:0] page_addr;
	logic [bmft_pkg::ADDR_W-1:0] copy_src;
	bmft_pkg::err_t              error_code;
	logic                        last;

	modport source (output valid, op, page_addr, copy_src, error_code, last, input ready);
	modport sink   (input valid, op, page_addr, copy_src, error_code, last, output ready);
endinterface

### src/block_mapping_flash_translation_core.sv
// ----------------------------------------------------------------------------
// block_mapping_flash_translation_core
// Block-mapped flash translation: turns sector read/write requests into flash
// commands (read, program, copy, erase, error).
//
// req carries one item per request (command, lsn); res carries the flash
// commands it causes, one item each, the final one marked by last.
// A read looks up the map store and then loads its item into the result
// register; the next request is taken only after that load. A write to an
// unmapped block scans the bitmap store, one block per cycle, up to all
// PHYSICAL_BLOCKS blocks. An overwrite walks PAGES_IN_BLOCK pages through
// the shared counter and issues PAGES_IN_BLOCK+1 items, plus a scan when the
// spare is in use. The sequencer handles one request at a time; req.ready
// is high only between requests, and the next request can be taken while the
// last item of the previous one still sits in the result register.
// After reset the bitmap store is cleared, one block per cycle, over all
// PHYSICAL_BLOCKS blocks, before the first request is taken.
// When res is stalled the result register holds and the sequencer waits.
// ----------------------------------------------------------------------------
module block_mapping_flash_translation_core #(
	parameter int PHYSICAL_BLOCKS = bmft_pkg::PHYSICAL_BLOCKS,
	parameter int LOGICAL_BLOCKS  = bmft_pkg::LOGICAL_BLOCKS
) (
	input  logic       clk,
	input  logic       arst_n,
	bmft_req_if.sink   req,
	bmft_res_if.source res
);

	localparam int BLK_W     = $clog2(PHYSICAL_BLOCKS);
	localparam int MAP_DEPTH = (LOGICAL_BLOCKS < bmft_pkg::LBN_SPAN) ?
		LOGICAL_BLOCKS : bmft_pkg::LBN_SPAN;
	localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int PG_W      = bmft_pkg::PAGES_IN_BLOCK;

	logic              map_ren;
	logic [MAP_AW-1:0] map_raddr;
	logic              map_wen;
	logic [MAP_AW-1:0] map_waddr;
	logic [BLK_W-1:0]  map_wdata;
	logic              map_rd_vld;
	logic [BLK_W-1:0]  map_rd_pbn;
	logic              pw_ren;
	logic [BLK_W-1:0]  pw_raddr;
	logic              pw_wen;
	logic [BLK_W-1:0]  pw_waddr;
	logic [PG_W-1:0]   pw_wdata;
	logic [PG_W-1:0]   pw_rdata;

	// Request sequencer
	bmft_seq #(
		.PHYSICAL_BLOCKS (PHYSICAL_BLOCKS),
		.LOGICAL_BLOCKS  (LOGICAL_BLOCKS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.res        (res),
		.map_ren    (map_ren),
		.map_raddr  (map_raddr),
		.map_wen    (map_wen),
		.map_waddr  (map_waddr),
		.map_wdata  (map_wdata),
		.map_rd_vld (map_rd_vld),
		.map_rd_pbn (map_rd_pbn),
		.pw_ren     (pw_ren),
		.pw_raddr   (pw_raddr),
		.pw_wen     (pw_wen),
		.pw_waddr   (pw_waddr),
		.pw_wdata   (pw_wdata),
		.pw_rdata   (pw_rdata)
	);

	// Logical-to-physical map
	bmft_map_mem #(
		.DEPTH (MAP_DEPTH),
		.DW    (BLK_W)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.ren    (map_ren),
		.raddr  (map_raddr),
		.wen    (map_wen),
		.waddr  (map_waddr),
		.wdata  (map_wdata),
		.rd_vld (map_rd_vld),
		.rd_pbn (map_rd_pbn)
	);

	// Written-page bitmaps
	bmft_pw_mem #(
		.DEPTH (PHYSICAL_BLOCKS)
	) u_pw (
		.clk   (clk),
		.ren   (pw_ren),
		.raddr (pw_raddr),
		.wen   (pw_wen),
		.waddr (pw_waddr),
		.wdata (pw_wdata),
		.rdata (pw_rdata)
	);

endmodule

### src/bmft_map_mem.sv
// ----------------------------------------------------------------------------
// bmft_map_mem
// Logical-to-physical block map: valid flags in flops, block numbers in RAM.
// ----------------------------------------------------------------------------
module bmft_map_mem #(
	parameter int  DEPTH = bmft_pkg::LOGICAL_BLOCKS,
	parameter int  DW    = $clog2(bmft_pkg::PHYSICAL_BLOCKS),
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ren,
	input  logic [AW-1:0] raddr,
	input  logic          wen,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	output logic          rd_vld,
	output logic [DW-1:0] rd_pbn
);

	logic [DEPTH-1:0] vld_q;
	logic [DW-1:0]    mem [DEPTH];
	logic             rd_vld_q;
	logic [DW-1:0]    rd_pbn_q;

	// Mapped flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wen) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// Block number store and registered read
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rd_vld_q <= vld_q[raddr];
			rd_pbn_q <= mem[raddr];
		end
	end

	assign rd_vld = rd_vld_q;
	assign rd_pbn = rd_pbn_q;

endmodule

### src/bmft_pw_mem.sv
// ----------------------------------------------------------------------------
// bmft_pw_mem
// Written-page bitmap, one word per physical block, registered read port.
// ----------------------------------------------------------------------------
module bmft_pw_mem #(
	parameter int  DEPTH = bmft_pkg::PHYSICAL_BLOCKS,
	localparam int AW    = $clog2(DEPTH),
	localparam int DW    = bmft_pkg::PAGES_IN_BLOCK
) (
	input  logic          clk,
	input  logic          ren,
	input  logic [AW-1:0] raddr,
	input  logic          wen,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	// One write and one read per cycle; read data holds when not enabled
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

### src/bmft_seq.sv
// ----------------------------------------------------------------------------
// bmft_seq
// Request sequencer: one shared block/page counter with zero and end compare,
// drives the map and bitmap stores and the result register.
// ----------------------------------------------------------------------------
module bmft_seq #(
	parameter int  PHYSICAL_BLOCKS = bmft_pkg::PHYSICAL_BLOCKS,
	parameter int  LOGICAL_BLOCKS  = bmft_pkg::LOGICAL_BLOCKS,
	localparam int BLK_W     = $clog2(PHYSICAL_BLOCKS),
	localparam int MAP_DEPTH = (LOGICAL_BLOCKS < bmft_pkg::LBN_SPAN) ?
		LOGICAL_BLOCKS : bmft_pkg::LBN_SPAN,
	localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1,
	localparam int PG_W      = bmft_pkg::PAGES_IN_BLOCK
) (
	input  logic              clk,
	input  logic              arst_n,
	bmft_req_if.sink          req,
	bmft_res_if.source        res,
	// map store
	output logic              map_ren,
	output logic [MAP_AW-1:0] map_raddr,
	output logic              map_wen,
	output logic [MAP_AW-1:0] map_waddr,
	output logic [BLK_W-1:0]  map_wdata,
	input  logic              map_rd_vld,
	input  logic [BLK_W-1:0]  map_rd_pbn,
	// bitmap store
	output logic              pw_ren,
	output logic [BLK_W-1:0]  pw_raddr,
	output logic              pw_wen,
	output logic [BLK_W-1:0]  pw_waddr,
	output logic [PG_W-1:0]   pw_wdata,
	input  logic [PG_W-1:0]   pw_rdata
);

	localparam int OFF_W  = bmft_pkg::OFF_W;
	localparam int LBN_W  = bmft_pkg::LBN_W;
	localparam int ADDR_W = bmft_pkg::ADDR_W;
	localparam int CNT_W  = (BLK_W > OFF_W) ? BLK_W : OFF_W;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_ZERO,
		CNT_INC
	} cnt_op_t;

	bmft_pkg::state_t   state_q, state_d;
	logic               cmd_q;
	logic [LBN_W-1:0]   lbn_q;
	logic [OFF_W-1:0]   off_q;
	logic               in_range_q;
	logic               ovw_q;
	logic [BLK_W-1:0]   pbn_q;
	logic [BLK_W-1:0]   blk_q;
	logic [BLK_W-1:0]   spare_q;
	logic [PG_W-1:0]    pw_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_nx;
	cnt_op_t            cnt_op;

	logic               res_vld_q;
	bmft_pkg::op_t      res_op_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic [ADDR_W-1:0]  res_src_q;
	bmft_pkg::err_t     res_err_q;
	logic               res_last_q;

	logic               rdy;
	logic               req_acc;
	logic               can_load;
	logic [LBN_W-1:0]   lbn_in;
	logic [BLK_W-1:0]   cnt_blk;
	logic [OFF_W-1:0]   cnt_pg;
	logic               blk_end;
	logic               pg_end;
	logic               pg_skip;
	logic               pw_zero;
	logic               bit_hit;
	logic [PG_W-1:0]    bit_mask;

	logic               emit_vld;
	bmft_pkg::op_t      emit_op;
	logic [ADDR_W-1:0]  emit_addr;
	logic [ADDR_W-1:0]  emit_src;
	bmft_pkg::err_t     emit_err;
	logic               emit_last;

	// Physical page address of (block, page), wrapped to the address width
	function automatic logic [ADDR_W-1:0] pg_addr(input logic [BLK_W-1:0] blk,
		input logic [OFF_W-1:0] pg);
		logic [ADDR_W+BLK_W+OFF_W-1:0] full;
		full = {{ADDR_W{1'b0}}, blk, pg};
		return full[ADDR_W-1:0];
	endfunction

	// Shared counter and its compares
	assign cnt_nx   = cnt_q + CNT_W'(1);
	assign cnt_blk  = cnt_q[BLK_W-1:0];
	assign cnt_pg   = cnt_q[OFF_W-1:0];
	assign blk_end  = (cnt_blk == BLK_W'(PHYSICAL_BLOCKS - 1));
	assign pg_end   = (cnt_pg == OFF_W'(bmft_pkg::PAGES_IN_BLOCK - 1));
	assign pg_skip  = (cnt_pg == off_q);
	assign pw_zero  = (pw_rdata == '0);
	assign bit_mask = PG_W'(1) << off_q;
	assign bit_hit  = |(pw_rdata & bit_mask);

	// Handshake
	assign lbn_in   = req.lsn[bmft_pkg::LSN_W-1:OFF_W];
	assign rdy      = (state_q == bmft_pkg::ST_IDLE);
	assign req_acc  = req.valid && rdy;
	assign can_load = !res_vld_q || res.ready;
	assign req.ready = rdy;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bmft_pkg::ST_CLEAR: begin
				if (blk_end) state_d = bmft_pkg::ST_IDLE;
			end
			bmft_pkg::ST_IDLE: begin
				if (req_acc) state_d = bmft_pkg::ST_MAP;
			end
			bmft_pkg::ST_MAP: begin
				priority if (!cmd_q) begin
					if (can_load) state_d = bmft_pkg::ST_IDLE;
				end else if (!in_range_q) begin
					state_d = bmft_pkg::ST_IDLE;
				end else if (!map_rd_vld) begin
					state_d = bmft_pkg::ST_SCAN;
				end else begin
					state_d = bmft_pkg::ST_PWR;
				end
			end
			bmft_pkg::ST_PWR: begin
				priority if (bit_hit) state_d = bmft_pkg::ST_SPR;
				else if (can_load) state_d = bmft_pkg::ST_IDLE;
				else state_d = state_q;
			end
			bmft_pkg::ST_SPR: begin
				state_d = pw_zero ? bmft_pkg::ST_COPY : bmft_pkg::ST_SCAN;
			end
			bmft_pkg::ST_SCAN: begin
				priority if (pw_zero) begin
					if (ovw_q) state_d = bmft_pkg::ST_COPY;
					else if (can_load) state_d = bmft_pkg::ST_IDLE;
				end else if (blk_end) begin
					if (can_load) state_d = bmft_pkg::ST_IDLE;
				end else begin
					state_d = state_q;
				end
			end
			bmft_pkg::ST_COPY: begin
				if ((pg_skip || can_load) && pg_end) state_d = bmft_pkg::ST_PROG;
			end
			bmft_pkg::ST_PROG: begin
				if (can_load) state_d = bmft_pkg::ST_ERASE;
			end
			bmft_pkg::ST_ERASE: begin
				if (can_load) state_d = bmft_pkg::ST_IDLE;
			end
			default: state_d = bmft_pkg::ST_IDLE;
		endcase
	end

	// Store controls, counter control and result generation
	always_comb begin
		map_ren   = req_acc;
		map_raddr = lbn_in[MAP_AW-1:0];
		map_wen   = 1'b0;
		map_waddr = lbn_q[MAP_AW-1:0];
		map_wdata = blk_q;
		pw_ren    = 1'b0;
		pw_raddr  = '0;
		pw_wen    = 1'b0;
		pw_waddr  = '0;
		pw_wdata  = '0;
		cnt_op    = CNT_HOLD;
		emit_vld  = 1'b0;
		emit_op   = bmft_pkg::OP_READ;
		emit_addr = '0;
		emit_src  = '0;
		emit_err  = bmft_pkg::ERR_NONE;
		emit_last = 1'b0;
		unique case (state_q)
			bmft_pkg::ST_CLEAR: begin
				pw_wen   = 1'b1;
				pw_waddr = cnt_blk;
				cnt_op   = CNT_INC;
			end
			bmft_pkg::ST_IDLE: begin
			end
			bmft_pkg::ST_MAP: begin
				priority if (!cmd_q) begin
					if (can_load) begin
						emit_vld  = 1'b1;
						emit_last = 1'b1;
						if (!in_range_q || !map_rd_vld) begin
							emit_op  = bmft_pkg::OP_ERROR;
							emit_err = bmft_pkg::ERR_UNMAPPED;
						end else begin
							emit_op   = bmft_pkg::OP_READ;
							emit_addr = pg_addr(map_rd_pbn, off_q);
						end
					end
				end else if (!in_range_q) begin
				end else if (!map_rd_vld) begin
					// start empty block search at block zero
					pw_ren = 1'b1;
					cnt_op = CNT_ZERO;
				end else begin
					pw_ren   = 1'b1;
					pw_raddr = map_rd_pbn;
				end
			end
			bmft_pkg::ST_PWR: begin
				priority if (bit_hit) begin
					pw_ren   = 1'b1;
					pw_raddr = spare_q;
				end else if (can_load) begin
					// program in place
					emit_vld  = 1'b1;
					emit_op   = bmft_pkg::OP_PROGRAM;
					emit_addr = pg_addr(pbn_q, off_q);
					emit_last = 1'b1;
					pw_wen    = 1'b1;
					pw_waddr  = pbn_q;
					pw_wdata  = pw_rdata | bit_mask;
				end else begin
				end
			end
			bmft_pkg::ST_SPR: begin
				cnt_op = CNT_ZERO;
				pw_ren = !pw_zero;
			end
			bmft_pkg::ST_SCAN: begin
				priority if (pw_zero) begin
					if (ovw_q) begin
						cnt_op = CNT_ZERO;
					end else if (can_load) begin
						// claim the empty block for the logical block
						emit_vld  = 1'b1;
						emit_op   = bmft_pkg::OP_PROGRAM;
						emit_addr = pg_addr(cnt_blk, off_q);
						emit_last = 1'b1;
						pw_wen    = 1'b1;
						pw_waddr  = cnt_blk;
						pw_wdata  = bit_mask;
						map_wen   = 1'b1;
						map_wdata = cnt_blk;
					end
				end else if (blk_end) begin
					if (can_load) begin
						emit_vld  = 1'b1;
						emit_op   = bmft_pkg::OP_ERROR;
						emit_err  = bmft_pkg::ERR_NO_EMPTY;
						emit_last = 1'b1;
					end
				end else begin
					pw_ren   = 1'b1;
					pw_raddr = cnt_nx[BLK_W-1:0];
					cnt_op   = CNT_INC;
				end
			end
			bmft_pkg::ST_COPY: begin
				priority if (pg_skip) begin
					cnt_op = CNT_INC;
				end else if (can_load) begin
					emit_vld  = 1'b1;
					emit_op   = bmft_pkg::OP_COPY;
					emit_addr = pg_addr(blk_q, cnt_pg);
					emit_src  = pg_addr(pbn_q, cnt_pg);
					cnt_op    = CNT_INC;
				end else begin
				end
			end
			bmft_pkg::ST_PROG: begin
				if (can_load) begin
					emit_vld  = 1'b1;
					emit_op   = bmft_pkg::OP_PROGRAM;
					emit_addr = pg_addr(blk_q, off_q);
					pw_wen    = 1'b1;
					pw_waddr  = blk_q;
					pw_wdata  = pw_q | bit_mask;
				end
			end
			bmft_pkg::ST_ERASE: begin
				if (can_load) begin
					// old block is wiped and becomes the spare
					emit_vld  = 1'b1;
					emit_op   = bmft_pkg::OP_ERASE;
					emit_addr = pg_addr(pbn_q, '0);
					emit_last = 1'b1;
					pw_wen    = 1'b1;
					pw_waddr  = pbn_q;
					map_wen   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bmft_pkg::ST_CLEAR;
			cnt_q     <= '0;
			spare_q   <= BLK_W'(PHYSICAL_BLOCKS - 1);
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (cnt_op)
				CNT_ZERO: cnt_q <= '0;
				CNT_INC:  cnt_q <= cnt_nx;
				default:  cnt_q <= cnt_q;
			endcase
			if (state_q == bmft_pkg::ST_ERASE && can_load) begin
				spare_q <= pbn_q;
			end
			if (emit_vld) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// Request fields, working copies and result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q      <= req.command;
			lbn_q      <= lbn_in;
			off_q      <= req.lsn[OFF_W-1:0];
			in_range_q <= (int'(lbn_in) < LOGICAL_BLOCKS);
		end
		if (state_q == bmft_pkg::ST_MAP) begin
			pbn_q <= map_rd_pbn;
			ovw_q <= 1'b0;
		end
		if (state_q == bmft_pkg::ST_PWR) begin
			pw_q <= pw_rdata;
		end
		if (state_q == bmft_pkg::ST_SPR) begin
			ovw_q <= 1'b1;
			blk_q <= spare_q;
		end
		if (state_q == bmft_pkg::ST_SCAN && pw_zero) begin
			blk_q <= cnt_blk;
		end
		if (emit_vld) begin
			res_op_q   <= emit_op;
			res_addr_q <= emit_addr;
			res_src_q  <= emit_src;
			res_err_q  <= emit_err;
			res_last_q <= emit_last;
		end
	end

	assign res.valid      = res_vld_q;
	assign res.op         = res_op_q;
	assign res.page_addr  = res_addr_q;
	assign res.copy_src   = res_src_q;
	assign res.error_code = res_err_q;
	assign res.last       = res_last_q;

`ifndef SYNTHESIS
	a_pw_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(pw_ren && pw_wen))
		else $error("bitmap read and write in the same cycle");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit_vld |-> (!res_vld_q || res.ready))
		else $error("result generated while result register is held");

	a_copy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmft_pkg::ST_COPY) |-> (blk_q != pbn_q))
		else $error("rebuild target equals source block");

	a_map_write: assert property (@(posedge clk) disable iff (!arst_n)
		map_wen |-> (in_range_q && cmd_q))
		else $error("map written outside an in-range write request");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_vld && emit_last) |=> (state_q == bmft_pkg::ST_IDLE))
		else $error("final result issued but request not finished");
`endif

endmodule

### dv/block_mapping_flash_translation_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_mapping_flash_translation_core_test
// Self-checking bench for the block-mapped flash translation core. Sector
// read/write requests go in on the req channel. A local model of the block
// map, page bitmaps and spare block predicts each flash command. The commands
// coming out of res are checked field by field, in order. Both channels idle
// at random, and there is one long result stall and two full drains.
// ----------------------------------------------------------------------------
module block_mapping_flash_translation_core_test;

	localparam int PAGES       = bmft_pkg::PAGES_IN_BLOCK;
	localparam int PBLOCKS     = bmft_pkg::PHYSICAL_BLOCKS;
	localparam int LBLOCKS     = bmft_pkg::LOGICAL_BLOCKS;
	localparam int ADDR_W      = bmft_pkg::ADDR_W;
	localparam int LSN_W       = bmft_pkg::LSN_W;
	localparam int PBN_W       = $clog2(PBLOCKS);
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_TAIL  = PBLOCKS + 16;
	localparam int RANDOM_REQS = 145;
	localparam int LONG_STALL  = 400;

	// One expected flash command
	typedef struct {
		bmft_pkg::op_t     op;
		logic [ADDR_W-1:0] page_addr;
		logic [ADDR_W-1:0] copy_src;
		bmft_pkg::err_t    error_code;
		logic              last;
	} flash_cmd_t;

	logic clk;
	logic arst_n;

	bmft_req_if req ();
	bmft_res_if res ();

	block_mapping_flash_translation_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	// Mirror of the translation state
	logic             lbn_mapped [LBLOCKS];
	logic [PBN_W-1:0] lbn_to_pbn [LBLOCKS];
	logic [PAGES-1:0] page_bits  [PBLOCKS];
	int               spare_pbn;

	flash_cmd_t pending_cmds [$];

	int error_count;
	int requests_sent;
	int cmds_checked;
	int rebuilds_seen;
	int stall_request;
	bit req_quiet;
	bit res_quiet;

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d commands outstanding", CYCLE_LIMIT,
			pending_cmds.size());
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Translation model
	// ------------------------------------------------------------------------
	function automatic void expect_cmd(bmft_pkg::op_t op, logic [ADDR_W-1:0] addr,
			logic [ADDR_W-1:0] src, bmft_pkg::err_t err, logic last);
		flash_cmd_t c;
		c.op         = op;
		c.page_addr  = addr;
		c.copy_src   = src;
		c.error_code = err;
		c.last       = last;
		pending_cmds.push_back(c);
	endfunction

	// lowest physical block with no written page, spare included; -1 if none
	function automatic int lowest_empty_block();
		for (int b = 0; b < PBLOCKS; b++)
			if (page_bits[b] == '0)
				return b;
		return -1;
	endfunction

	function automatic void translate_request(logic cmd, logic [LSN_W-1:0] lsn);
		int               offset;
		int               lbn;
		int               pbn;
		int               blk;
		logic [PAGES-1:0] page_mask;
		offset    = int'(lsn) % PAGES;
		lbn       = int'(lsn) / PAGES;
		page_mask = PAGES'(1) << offset;

		if (cmd == 1'b0) begin
			if (lbn >= LBLOCKS || !lbn_mapped[lbn])
				expect_cmd(bmft_pkg::OP_ERROR, '0, '0, bmft_pkg::ERR_UNMAPPED, 1'b1);
			else
				expect_cmd(bmft_pkg::OP_READ,
					ADDR_W'(int'(lbn_to_pbn[lbn]) * PAGES + offset), '0,
					bmft_pkg::ERR_NONE, 1'b1);
			return;
		end

		// writes beyond the logical space are dropped silently
		if (lbn >= LBLOCKS)
			return;

		if (!lbn_mapped[lbn]) begin
			blk = lowest_empty_block();
			if (blk < 0) begin
				expect_cmd(bmft_pkg::OP_ERROR, '0, '0, bmft_pkg::ERR_NO_EMPTY, 1'b1);
				return;
			end
			expect_cmd(bmft_pkg::OP_PROGRAM, ADDR_W'(blk * PAGES + offset), '0,
				bmft_pkg::ERR_NONE, 1'b1);
			page_bits[blk]  |= page_mask;
			lbn_mapped[lbn]  = 1'b1;
			lbn_to_pbn[lbn]  = PBN_W'(blk);
			return;
		end

		pbn = int'(lbn_to_pbn[lbn]);
		if ((page_bits[pbn] & page_mask) == '0) begin
			expect_cmd(bmft_pkg::OP_PROGRAM, ADDR_W'(pbn * PAGES + offset), '0,
				bmft_pkg::ERR_NONE, 1'b1);
			page_bits[pbn] |= page_mask;
			return;
		end

		// overwrite: rebuild into the spare, or a fresh empty block if spare is used
		blk = spare_pbn;
		if (page_bits[blk] != '0) begin
			blk = lowest_empty_block();
			if (blk < 0) begin
				expect_cmd(bmft_pkg::OP_ERROR, '0, '0, bmft_pkg::ERR_NO_EMPTY, 1'b1);
				return;
			end
		end
		for (int p = 0; p < PAGES; p++)
			if (p != offset)
				expect_cmd(bmft_pkg::OP_COPY, ADDR_W'(blk * PAGES + p),
					ADDR_W'(pbn * PAGES + p), bmft_pkg::ERR_NONE, 1'b0);
		expect_cmd(bmft_pkg::OP_PROGRAM, ADDR_W'(blk * PAGES + offset), '0,
			bmft_pkg::ERR_NONE, 1'b0);
		expect_cmd(bmft_pkg::OP_ERASE, ADDR_W'(pbn * PAGES), '0,
			bmft_pkg::ERR_NONE, 1'b1);
		page_bits[blk] = page_bits[pbn] | page_mask;
		page_bits[pbn] = '0;
		lbn_to_pbn[lbn] = PBN_W'(blk);
		spare_pbn = pbn;
		rebuilds_seen++;
	endfunction

	initial begin
		for (int i = 0; i < LBLOCKS; i++) begin
			lbn_mapped[i] = 1'b0;
			lbn_to_pbn[i] = '0;
		end
		for (int i = 0; i < PBLOCKS; i++)
			page_bits[i] = '0;
		spare_pbn = PBLOCKS - 1;
	end

	// ------------------------------------------------------------------------
	// Result side: ready pattern and checking
	// ------------------------------------------------------------------------
	initial begin
		int gap;
		res.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (stall_request > 0) begin
				gap = stall_request;
				stall_request = 0;
			end else begin
				gap = res_quiet ? 0 : int'($urandom_range(0, 7));
			end
			if (gap != 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		flash_cmd_t want;
		if (arst_n && res.valid === 1'b1 && res.ready === 1'b1) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual op %0d addr %0d",
					$time, res.op, res.page_addr);
				error_count++;
			end else begin
				want = pending_cmds.pop_front();
				check_field("op", 16'(want.op), 16'(res.op));
				check_field("page_addr", 16'(want.page_addr), 16'(res.page_addr));
				check_field("copy_src", 16'(want.copy_src), 16'(res.copy_src));
				check_field("error_code", 16'(want.error_code), 16'(res.error_code));
				check_field("last", 16'(want.last), 16'(res.last));
				cmds_checked++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------
	task automatic send_request(input logic cmd, input logic [LSN_W-1:0] lsn);
		int gap;
		gap = req_quiet ? 0 : int'($urandom_range(0, 7));
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid   <= 1'b1;
		req.command <= cmd;
		req.lsn     <= lsn;
		do @(posedge clk); while (!req.ready);
		translate_request(cmd, lsn);
		requests_sent++;
	endtask

	// hold the request side until every predicted command has come out
	task automatic wait_for_drain();
		req.valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_unmapped_access();
		send_request(1'b0, 11'd0);
		send_request(1'b0, 11'd2047);
		send_request(1'b0, 11'd2016);
		send_request(1'b1, 11'd2047);
		send_request(1'b1, 11'd2016);
	endtask

	task automatic test_first_writes();
		send_request(1'b1, 11'd0);     // new block
		send_request(1'b0, 11'd0);
		send_request(1'b0, 11'd31);    // unwritten page, still read
		send_request(1'b1, 11'd31);    // in place
		send_request(1'b1, 11'd2015);  // last logical sector
		send_request(1'b0, 11'd2015);
		send_request(1'b1, 11'd1);
	endtask

	task automatic test_block_rebuild();
		send_request(1'b1, 11'd0);     // rebuild into the initial spare
		send_request(1'b1, 11'd1024);  // new block lands on the empty spare
		send_request(1'b1, 11'd1024);  // spare is in use, search for another
		send_request(1'b1, 11'd31);
		send_request(1'b1, 11'd1055);
		send_request(1'b0, 11'd31);
		send_request(1'b0, 11'd1024);
		send_request(1'b0, 11'd1025);
	endtask

	task automatic test_backpressure();
		req_quiet = 1'b1;
		stall_request = LONG_STALL;
		send_request(1'b1, 11'd0);
		send_request(1'b1, 11'd2015);
		send_request(1'b0, 11'd0);
		send_request(1'b1, 11'd1024);
		send_request(1'b1, 11'd100);
		send_request(1'b0, 11'd2015);
		req_quiet = 1'b0;
		wait_for_drain();
	endtask

	task automatic test_random_traffic();
		int               counted;
		int               sel;
		int               hot_lbn;
		int               hot_off;
		logic             cmd;
		logic [LSN_W-1:0] lsn;
		counted = 0;
		while (counted < RANDOM_REQS) begin
			// switch idling on or off every so often
			if (counted % 20 == 0) begin
				req_quiet = ($urandom_range(0, 3) == 0);
				res_quiet = ($urandom_range(0, 3) == 0);
			end
			sel     = int'($urandom_range(0, 99));
			hot_lbn = ($urandom_range(0, 7) == 0) ? LBLOCKS - 1 : int'($urandom_range(0, 5));
			hot_off = ($urandom_range(0, 5) == 0) ? PAGES - 1 : int'($urandom_range(0, 3));
			if (sel < 45) begin
				cmd = 1'b1;
				lsn = LSN_W'(hot_lbn * PAGES + hot_off);
			end else if (sel < 65) begin
				cmd = 1'b1;
				lsn = LSN_W'($urandom_range(0, 2047));
			end else if (sel < 80) begin
				cmd = 1'b0;
				lsn = LSN_W'(hot_lbn * PAGES + hot_off);
			end else if (sel < 92) begin
				cmd = 1'b0;
				lsn = LSN_W'($urandom_range(0, 2047));
			end else begin
				cmd = 1'($urandom_range(0, 1));
				lsn = LSN_W'($urandom_range(LBLOCKS * PAGES, 2047));
			end
			send_request(cmd, lsn);
			if (!(cmd && int'(lsn) / PAGES >= LBLOCKS))
				counted++;
		end
		req_quiet = 1'b0;
		res_quiet = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		error_count   = 0;
		requests_sent = 0;
		cmds_checked  = 0;
		rebuilds_seen = 0;
		stall_request = 0;
		req_quiet     = 1'b0;
		res_quiet     = 1'b0;
		req.valid   <= 1'b0;
		req.command <= 1'b0;
		req.lsn     <= '0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		test_unmapped_access();
		test_first_writes();
		test_block_rebuild();
		test_backpressure();
		test_random_traffic();
		wait_for_drain();

		if (pending_cmds.size() != 0) begin
			$display("%0t: %0d expected commands never arrived", $time, pending_cmds.size());
			error_count++;
		end
		$display("%0d requests (reads, writes, rebuilds, out-of-range), %0d commands checked",
			requests_sent, cmds_checked);
		$display("%0d block rebuilds, %0d mismatches", rebuilds_seen, error_count);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
